[sv/cbrs_pkg.sv]
`timescale 1ns / 1ps
// Package for the chunked rank/select bitvector unit.
// It holds field widths, operation and status codes, default sizes and the state type.
// It has no dependencies.
package cbrs_pkg;

  localparam int CHUNK_WIDTH_DEF = 32;
  localparam int MAX_CHUNKS_DEF  = 1024;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 16;
  localparam int STAT_W = 2;
  localparam int ANS_W  = 15;
  localparam int BASE_W = 16;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SETPOS = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SETLEN = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RANK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SELECT = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_A,
    S_DIV_B,
    S_DIV_C,
    S_SETPOS,
    S_POP_WAIT,
    S_APPEND,
    S_RMW_RD,
    S_RMW_WAIT,
    S_RANK_CHK,
    S_RANK_WAIT,
    S_BS_ISSUE,
    S_BS_WAIT,
    S_SEL_RD,
    S_SEL_WAIT,
    S_SCAN,
    S_SCAN_END,
    S_FINISH
  } state_t;

endpackage

[sv/chunked_bitvector_rank_select_unit.sv]
`timescale 1ns / 1ps
// Top level of the chunked rank/select bitvector unit for one alignment row.
// It holds the chunk memories, the sequencer, a divider by the chunk width and a bit scanner.
// It depends on cbrs_pkg.
//
//   channel   direction  fields (tuser / tdata)
//   s_*       in         func / position
//   m_*       out        status / answer
//   cfg_*     in         fragment_length
//
// Clear, set length and unused codes go from decode straight to the finish step.
// Rank divides the position by the chunk width, then the bit scanner counts the set bits
// below the offset in its chunk, one bit per cycle. Set position appends chunks up to the
// target and then sets the bit by a read, modify and write. Select binary-searches the
// chunk bases, read from the single memory port, then scans the chosen chunk for the bit.
// Reset is synchronous; the chunk memories are not cleared. The sequencer waits in its last
// state only while the output register still holds an unaccepted result; otherwise the
// result moves there and the next input beat is taken.
module chunked_bitvector_rank_select_unit
  import cbrs_pkg::*;
#(
  parameter int CHUNK_WIDTH = CHUNK_WIDTH_DEF,
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [FUNC_W-1:0] s_tuser,   // func[2:0]
  input  logic [POS_W-1:0]  s_tdata,   // position[15:0]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [STAT_W-1:0] m_tuser,   // status[1:0]
  output logic [15:0]       m_tdata,   // answer[14:0], zero[15]
  input  logic              cfg_we,
  input  logic [POS_W-1:0]  cfg_wdata  // fragment_length[15:0]
);

  localparam int AW    = $clog2(MAX_CHUNKS);
  localparam int CW_W  = $clog2(MAX_CHUNKS + 1);
  localparam int OW    = $clog2(CHUNK_WIDTH);
  localparam int OW1   = $clog2(CHUNK_WIDTH + 1);
  localparam int SW    = AW + 7;
  localparam int QW    = POS_W + 7;
  localparam int MW    = 20;
  localparam int DIV_SHIFT = 22;
  localparam logic [MW-1:0] DIV_MUL = MW'((1 << DIV_SHIFT) / CHUNK_WIDTH);
  localparam logic [POS_W-1:0] MAX_CHUNKS_P = POS_W'(MAX_CHUNKS);
  localparam logic [POS_W-1:0] CW_P = POS_W'(CHUNK_WIDTH);

  state_t state, state_next;

  logic [CHUNK_WIDTH-1:0] bits_mem [MAX_CHUNKS];
  logic [BASE_W-1:0]      base_mem [MAX_CHUNKS];
  logic [CHUNK_WIDTH-1:0] rd_bits;
  logic [BASE_W-1:0]      rd_base;
  logic [AW-1:0]          mem_addr;
  logic                   bits_we;
  logic                   base_we;
  logic [CHUNK_WIDTH-1:0] mem_wbits;
  logic [BASE_W-1:0]      mem_wbase;

  logic [CW_W-1:0]   chunk_count;
  logic [POS_W-1:0]  row_length;
  logic [POS_W-1:0]  fragment_length;

  logic [FUNC_W-1:0] func_r;
  logic [POS_W-1:0]  pos_r;
  logic [POS_W+MW-1:0] prod;
  logic [POS_W-1:0]  quot;
  logic [QW-1:0]     quot_cw;
  logic [POS_W-1:0]  rem;
  logic [POS_W-1:0]  idx;
  logic [OW-1:0]     off;
  logic [BASE_W-1:0] new_base;
  logic [BASE_W-1:0] base_reg;

  logic [CW_W-1:0]   lo;
  logic [CW_W-1:0]   hi;
  logic [CW_W-1:0]   mid;
  logic [CW_W:0]     mid_sum;
  logic [CW_W-1:0]   mid_comb;
  logic [CW_W-1:0]   sel;
  logic [SW-1:0]     sel_start;
  logic [POS_W-1:0]  k_reg;

  logic [CHUNK_WIDTH-1:0] scan_bits;
  logic [OW1-1:0]    scan_cnt;
  logic [OW1-1:0]    scan_limit;
  logic [OW1-1:0]    seen;
  logic [OW1-1:0]    hit_pos;
  logic              scan_hit;
  logic              sel_none;

  logic [STAT_W-1:0] res_status;
  logic [ANS_W-1:0]  res_answer;
  logic              out_load;

  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_comb = mid_sum[CW_W:1];
  assign rem      = pos_r - quot_cw[POS_W-1:0];
  assign scan_hit = (func_r == FUNC_SELECT) && scan_bits[0] && (POS_W'(seen) == k_reg);
  assign sel_none = (pos_r >= row_length) ||
                    ((fragment_length != '0) && (pos_r >= fragment_length));
  assign out_load = (state == S_FINISH) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (func_r)
          FUNC_SETPOS, FUNC_RANK: state_next = S_DIV_A;
          FUNC_SELECT: state_next = sel_none ? S_FINISH : S_BS_ISSUE;
          default: state_next = S_FINISH;
        endcase
      end
      S_DIV_A: state_next = S_DIV_B;
      S_DIV_B: state_next = S_DIV_C;
      S_DIV_C: state_next = (func_r == FUNC_SETPOS) ? S_SETPOS : S_RANK_CHK;
      S_SETPOS: begin
        if (idx >= MAX_CHUNKS_P) state_next = S_FINISH;
        else if (POS_W'(chunk_count) > idx) state_next = S_RMW_RD;
        else if (chunk_count == '0) state_next = S_APPEND;
        else state_next = S_POP_WAIT;
      end
      S_POP_WAIT: state_next = S_SCAN;
      S_APPEND: begin
        if (POS_W'(chunk_count) == idx) state_next = S_RMW_RD;
      end
      S_RMW_RD: state_next = S_RMW_WAIT;
      S_RMW_WAIT: state_next = S_FINISH;
      S_RANK_CHK: begin
        if ((pos_r >= row_length) || (idx >= POS_W'(chunk_count))) state_next = S_FINISH;
        else state_next = S_RANK_WAIT;
      end
      S_RANK_WAIT: state_next = rd_bits[off] ? S_SCAN : S_FINISH;
      S_BS_ISSUE: begin
        if (lo < hi) state_next = S_BS_WAIT;
        else if (lo == '0) state_next = S_FINISH;
        else state_next = S_SEL_RD;
      end
      S_BS_WAIT: state_next = S_BS_ISSUE;
      S_SEL_RD: state_next = S_SEL_WAIT;
      S_SEL_WAIT: state_next = S_SCAN;
      S_SCAN: begin
        if ((scan_cnt == scan_limit) || scan_hit) state_next = S_SCAN_END;
      end
      S_SCAN_END: state_next = (func_r == FUNC_SETPOS) ? S_APPEND : S_FINISH;
      S_FINISH: begin
        if (!m_tvalid || m_tready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == S_IDLE);
    mem_addr  = '0;
    bits_we   = 1'b0;
    base_we   = 1'b0;
    mem_wbits = '0;
    mem_wbase = new_base;
    case (state)
      S_SETPOS: begin
        if (chunk_count != '0) mem_addr = AW'(chunk_count - 1'b1);
      end
      S_APPEND: begin
        mem_addr = chunk_count[AW-1:0];
        bits_we  = 1'b1;
        base_we  = 1'b1;
      end
      S_RMW_RD, S_RANK_CHK: mem_addr = idx[AW-1:0];
      S_RMW_WAIT: begin
        mem_addr  = idx[AW-1:0];
        bits_we   = 1'b1;
        mem_wbits = rd_bits | (CHUNK_WIDTH'(1) << off);
      end
      S_BS_ISSUE: mem_addr = mid_comb[AW-1:0];
      S_SEL_RD: mem_addr = sel[AW-1:0];
      default: mem_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (bits_we) bits_mem[mem_addr] <= mem_wbits;
    if (base_we) base_mem[mem_addr] <= mem_wbase;
    rd_bits <= bits_mem[mem_addr];
    rd_base <= base_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      chunk_count     <= '0;
      row_length      <= '0;
      fragment_length <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) fragment_length <= cfg_wdata;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      case (state)
        S_DECODE: begin
          if (func_r == FUNC_CLEAR) begin
            chunk_count <= '0;
            row_length  <= '0;
          end else if (func_r == FUNC_SETLEN) begin
            row_length <= pos_r;
          end
        end
        S_APPEND: chunk_count <= chunk_count + 1'b1;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {1'b0, res_answer};
    end
    case (state)
      S_IDLE: begin
        func_r <= s_tuser;
        pos_r  <= s_tdata;
      end
      S_DECODE: begin
        res_status <= ((func_r == FUNC_SELECT) && sel_none) ? ST_NONE : ST_OK;
        res_answer <= '0;
        lo         <= '0;
        hi         <= chunk_count;
      end
      S_DIV_A: prod <= (POS_W+MW)'(pos_r) * (POS_W+MW)'(DIV_MUL);
      S_DIV_B: begin
        quot    <= POS_W'(prod >> DIV_SHIFT);
        quot_cw <= QW'(POS_W'(prod >> DIV_SHIFT)) * QW'(CHUNK_WIDTH);
      end
      S_DIV_C: begin
        if (rem >= CW_P) begin
          idx <= quot + 1'b1;
          off <= OW'(rem - CW_P);
        end else begin
          idx <= quot;
          off <= OW'(rem);
        end
      end
      S_SETPOS: begin
        new_base <= '0;
        if (idx >= MAX_CHUNKS_P) res_status <= ST_FULL;
      end
      S_POP_WAIT: begin
        scan_bits  <= rd_bits;
        base_reg   <= rd_base;
        scan_cnt   <= '0;
        scan_limit <= OW1'(CHUNK_WIDTH);
        seen       <= '0;
        hit_pos    <= '0;
      end
      S_RANK_CHK: begin
        if ((pos_r >= row_length) || (idx >= POS_W'(chunk_count))) res_status <= ST_NONE;
      end
      S_RANK_WAIT: begin
        if (!rd_bits[off]) res_status <= ST_NONE;
        scan_bits  <= rd_bits;
        base_reg   <= rd_base;
        scan_cnt   <= '0;
        scan_limit <= OW1'(off);
        seen       <= '0;
        hit_pos    <= '0;
      end
      S_BS_ISSUE: begin
        mid <= mid_comb;
        sel <= lo - 1'b1;
        if ((lo >= hi) && (lo == '0)) res_status <= ST_NONE;
      end
      S_BS_WAIT: begin
        if (rd_base <= pos_r) lo <= mid + 1'b1;
        else hi <= mid;
      end
      S_SEL_RD: sel_start <= SW'(sel[AW-1:0]) * SW'(CHUNK_WIDTH);
      S_SEL_WAIT: begin
        k_reg      <= pos_r - rd_base;
        scan_bits  <= rd_bits;
        scan_cnt   <= '0;
        scan_limit <= OW1'(CHUNK_WIDTH);
        seen       <= '0;
        hit_pos    <= '0;
      end
      S_SCAN: begin
        if (scan_hit) begin
          hit_pos <= scan_cnt;
        end else if (scan_cnt != scan_limit) begin
          seen      <= seen + OW1'(scan_bits[0]);
          scan_bits <= scan_bits >> 1;
          scan_cnt  <= scan_cnt + 1'b1;
        end
      end
      S_SCAN_END: begin
        case (func_r)
          FUNC_SETPOS: new_base <= base_reg + BASE_W'(seen);
          FUNC_RANK: res_answer <= ANS_W'(base_reg + BASE_W'(seen));
          FUNC_SELECT: res_answer <= ANS_W'(sel_start + SW'(hit_pos));
          default: res_answer <= '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(chunk_count) <= MAX_CHUNKS)
    else $error("chunk count exceeds capacity");

  a_append_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPEND) |-> (POS_W'(chunk_count) <= idx))
    else $error("append past the target chunk");

  a_rmw_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW_WAIT) |-> (POS_W'(chunk_count) > idx))
    else $error("bit write to a chunk that was never appended");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_BS_ISSUE) |-> ((lo <= hi) && (hi <= chunk_count)))
    else $error("search bounds crossed");

  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_FINISH))
    else $error("result raised outside the finish step");

endmodule

[test/chunked_bitvector_rank_select_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for chunked_bitvector_rank_select_unit: directed rows, capacity and
// fragment bound cases, then random rows under several idle and stall mixes.
// It depends on cbrs_pkg and the unit's top level; it checks every result against its own row model.
module chunked_bitvector_rank_select_unit_tb;
  import cbrs_pkg::*;

  localparam int CW = CHUNK_WIDTH_DEF;
  localparam int MAXC = MAX_CHUNKS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [FUNC_W-1:0] op;
    logic [POS_W-1:0]  pos;
    logic [STAT_W-1:0] status;
    logic [ANS_W-1:0]  answer;
  } row_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic [POS_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [STAT_W-1:0] m_tuser;
  logic [15:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [POS_W-1:0] cfg_wdata = '0;

  logic [CW-1:0] chunk_bits_m [0:MAXC-1];
  logic [BASE_W-1:0] chunk_base_m [0:MAXC-1];
  int unsigned n_chunks = 0;
  logic [POS_W-1:0] row_len = '0;
  logic [POS_W-1:0] frag_len = '0;

  row_result_t expected_results[$];
  int beats_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  chunked_bitvector_rank_select_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser(s_tuser),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tuser(m_tuser),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic row_result_t predict_row_op(logic [FUNC_W-1:0] op, logic [POS_W-1:0] pos);
    row_result_t r;
    int unsigned idx, off, i, seen, hit;
    logic [POS_W-1:0] k;
    logic [CW-1:0] below;
    bit found, picked;
    r.op = op;
    r.pos = pos;
    r.status = ST_OK;
    r.answer = '0;
    idx = pos / CW;
    off = pos % CW;
    case (op)
      FUNC_CLEAR: begin
        n_chunks = 0;
        row_len = '0;
      end
      FUNC_SETPOS: begin
        if (idx >= MAXC) begin
          r.status = ST_FULL;
        end else begin
          while (n_chunks <= idx) begin
            if (n_chunks == 0) chunk_base_m[0] = '0;
            else chunk_base_m[n_chunks] = 16'(chunk_base_m[n_chunks-1] +
                                              $countones(chunk_bits_m[n_chunks-1]));
            chunk_bits_m[n_chunks] = '0;
            n_chunks++;
          end
          chunk_bits_m[idx][off] = 1'b1;
        end
      end
      FUNC_SETLEN: row_len = pos;
      FUNC_RANK: begin
        if (pos >= row_len || idx >= n_chunks || !chunk_bits_m[idx][off]) begin
          r.status = ST_NONE;
        end else begin
          below = chunk_bits_m[idx] & ((CW'(1) << off) - CW'(1));
          r.answer = 15'(chunk_base_m[idx] + $countones(below));
        end
      end
      FUNC_SELECT: begin
        if (pos >= row_len || (frag_len != 0 && pos >= frag_len)) begin
          r.status = ST_NONE;
        end else begin
          found = 1'b0;
          i = n_chunks;
          while (i > 0 && !found) begin
            i--;
            if (chunk_base_m[i] <= pos) found = 1'b1;
          end
          if (!found) begin
            r.status = ST_NONE;
          end else begin
            // A fragment index past the chunk's last set bit falls back to the chunk start.
            k = pos - chunk_base_m[i];
            seen = 0;
            hit = 0;
            picked = 1'b0;
            for (int b = 0; b < CW; b++) begin
              if (chunk_bits_m[i][b] && !picked) begin
                if (seen == k) begin
                  hit = b;
                  picked = 1'b1;
                end
                seen++;
              end
            end
            r.answer = 15'(i * CW + hit);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    $display("MISMATCH at cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", m_tdata, 0);
      end else begin
        want = expected_results.pop_front();
        if (m_tuser !== want.status)
          report_mismatch($sformatf("status of func %0d pos %0d", want.op, want.pos),
                          m_tuser, want.status);
        if (m_tdata !== {1'b0, want.answer})
          report_mismatch($sformatf("answer of func %0d pos %0d", want.op, want.pos),
                          m_tdata, want.answer);
        results_checked++;
      end
    end
  end

  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= pos;
    do @(posedge clk); while (!s_tready);
    expected_results.push_back(predict_row_op(op, pos));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (expected_results.size() != 0);
  endtask

  task automatic write_fragment_length(input logic [POS_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    frag_len = value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed_row();
    logic [FUNC_W-1:0] op;
    wait_idle();
    write_fragment_length('0);
    send_op(FUNC_CLEAR, '0);
    send_op(FUNC_RANK, '0);
    send_op(FUNC_SETLEN, 16'd100);
    send_op(FUNC_SELECT, '0);
    send_op(FUNC_SETPOS, 16'd0);
    send_op(FUNC_SETPOS, 16'd31);
    send_op(FUNC_SETPOS, 16'd32);
    send_op(FUNC_SETPOS, 16'd100);
    send_op(FUNC_SETPOS, 16'd16);
    send_op(FUNC_SETLEN, 16'd200);
    send_op(FUNC_RANK, 16'd31);
    send_op(FUNC_RANK, 16'd32);
    send_op(FUNC_RANK, 16'd50);
    send_op(FUNC_RANK, 16'd100);
    send_op(FUNC_SELECT, 16'd3);
    send_op(FUNC_SELECT, 16'd4);
    send_op(FUNC_SELECT, 16'd200);
    send_op(FUNC_SETPOS, 16'hFFFF);
    for (op = FUNC_SPARE_FIRST; op != FUNC_CLEAR; op++) send_op(op, 16'hFFFF);
  endtask

  task automatic test_capacity_edge();
    send_op(FUNC_CLEAR, 16'hFFFF);
    send_op(FUNC_SETPOS, 16'd0);
    send_op(FUNC_SETPOS, 16'd32767);
    send_op(FUNC_SETLEN, 16'hFFFF);
    send_op(FUNC_RANK, 16'd32767);
    send_op(FUNC_SETPOS, 16'd32768);
  endtask

  task automatic test_fragment_bound();
    wait_idle();
    write_fragment_length(16'd2);
    send_op(FUNC_SELECT, 16'd1);
    send_op(FUNC_SELECT, 16'd2);
    wait_idle();
    write_fragment_length('0);
    send_op(FUNC_SELECT, 16'd2);
  endtask

  task automatic build_and_query_row();
    logic [POS_W-1:0] marks[$];
    int unsigned last, n_marks, n_queries;
    logic [POS_W-1:0] len;
    send_op(FUNC_CLEAR, 16'($urandom));
    last = ($urandom_range(9) == 0) ? $urandom_range(0, 32700) : $urandom_range(0, 40);
    n_marks = $urandom_range(1, 24);
    for (int m = 0; m < n_marks && last <= 16'hFFFF; m++) begin
      send_op(FUNC_SETPOS, 16'(last));
      marks.push_back(16'(last));
      last += ($urandom_range(9) == 0) ? $urandom_range(33, 300) : $urandom_range(1, 12);
    end
    case ($urandom_range(9))
      0: len = 16'($urandom_range(0, last));
      1: len = 16'hFFFF;
      default: len = 16'(last + $urandom_range(0, 64));
    endcase
    send_op(FUNC_SETLEN, len);
    n_queries = $urandom_range(4, 20);
    for (int q = 0; q < n_queries; q++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_op(FUNC_RANK, marks[$urandom_range(marks.size() - 1)]);
        4: send_op(FUNC_RANK, 16'($urandom_range(0, last + 40)));
        5, 6, 7, 8: send_op(FUNC_SELECT, 16'($urandom_range(0, marks.size() + 2)));
        default: begin
          case ($urandom_range(4))
            0: send_op(FUNC_SETPOS, 16'($urandom_range(0, last)));
            1: send_op(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)), 16'($urandom));
            2: send_op(FUNC_RANK, 16'($urandom));
            3: send_op(FUNC_SELECT, 16'($urandom));
            default: begin
              if ($urandom_range(3) == 0) send_op(FUNC_SETPOS, 16'($urandom));
              else send_op(FUNC_SETLEN, 16'($urandom));
            end
          endcase
        end
      endcase
    end
  endtask

  task automatic test_random_rows(input int src_pct, input int snk_pct,
                                  input logic [POS_W-1:0] frag, input int n_items);
    int target;
    wait_idle();
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    write_fragment_length(frag);
    target = beats_sent + n_items;
    while (beats_sent < target) build_and_query_row();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_row();
    test_capacity_edge();
    test_fragment_bound();
    test_random_rows(0, 0, '0, 310);
    test_random_rows(52, 0, 16'($urandom_range(1, 24)), 310);
    test_random_rows(0, 52, 16'd32768, 310);
    test_random_rows(38, 38, 16'hFFFF, 310);
    wait_idle();
    repeat (60) @(negedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", 0, expected_results.size());
    $display("Covered directed rows, the chunk capacity edge, fragment bounds and random rows");
    $display("under four idle/stall mixes: %0d beats sent, %0d results checked, %0d mismatches.",
             beats_sent, results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
